// File: src/summed_area_rectangle_sum_assert.svh
// Assertion macros shared by the summed-area rectangle sum modules.
// Included by sars_ctrl and sars_dp; relies on a clock and an active-low reset.
`ifndef SUMMED_AREA_RECTANGLE_SUM_ASSERT_SVH
`define SUMMED_AREA_RECTANGLE_SUM_ASSERT_SVH

// Same-cycle implication.
`define SARS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SARS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sars_pkg.sv
// Types and constants for the summed-area rectangle sum block.
// No dependencies; imported by sars_ctrl, sars_dp and the top level.
package sars_pkg;

  localparam int SUM_W    = 28;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int VALUE_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BOUNDS = 2'd1,
    ST_NOT_READY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD_WR,
    S_QUERY_RD2,
    S_QUERY_SUM
  } state_t;

  typedef struct packed {
    logic accept_load;
    logic accept_query;
    logic load_write;
    logic query_second;
    logic query_finish;
  } sars_cmd_t;

endpackage

// File: src/sars_ctrl.sv
// Controller state machine for the summed-area rectangle sum block.
// Depends on sars_pkg and summed_area_rectangle_sum_assert.svh.
`include "summed_area_rectangle_sum_assert.svh"

module sars_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                func,
  output logic                busy,
  output sars_pkg::sars_cmd_t cmd
);
  import sars_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (func == FUNC_QUERY) ? S_QUERY_RD2 : S_LOAD_WR;
        end
      end
      S_LOAD_WR:   state_nxt = S_IDLE;
      S_QUERY_RD2: state_nxt = S_QUERY_SUM;
      S_QUERY_SUM: state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy              = (state_r != S_IDLE);
    cmd.accept_load   = accept && (func == FUNC_LOAD);
    cmd.accept_query  = accept && (func == FUNC_QUERY);
    cmd.load_write    = (state_r == S_LOAD_WR);
    cmd.query_second  = (state_r == S_QUERY_RD2);
    cmd.query_finish  = (state_r == S_QUERY_SUM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SARS_ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "more than one command")
  `SARS_ASSERT_NEXT(a_query_two_reads, clk, rst_n, cmd.accept_query,
                    cmd.query_second, "query skipped second read")
  `SARS_ASSERT_NEXT(a_load_single_write, clk, rst_n, cmd.load_write,
                    !busy, "load write not followed by idle")

endmodule

// File: src/sars_dp.sv
// Datapath for the summed-area rectangle sum block: table memory, load
// position, running row sum and query arithmetic. Depends on sars_pkg and
// summed_area_rectangle_sum_assert.svh.
`include "summed_area_rectangle_sum_assert.svh"

module sars_dp #(
  parameter int MAX_DIM      = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sars_pkg::sars_cmd_t                 cmd,
  input  logic signed [sars_pkg::VALUE_W-1:0] in_value,
  input  logic [sars_pkg::POS_W-1:0]          in_top_row,
  input  logic [sars_pkg::POS_W-1:0]          in_left_col,
  input  logic [sars_pkg::POS_W-1:0]          in_bottom_row,
  input  logic [sars_pkg::POS_W-1:0]          in_right_col,
  input  logic                                cfg_we,
  input  logic [sars_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sars_pkg::CNT_W-1:0]          cfg_data,
  output logic                                out_valid,
  output logic signed [sars_pkg::SUM_W-1:0]   out_rect_sum,
  output logic [sars_pkg::STATUS_W-1:0]       out_status
);
  import sars_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int DW    = (CW > POS_W) ? CW : POS_W;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int EB    = (ELEMENT_BITS < VALUE_W) ? ELEMENT_BITS : VALUE_W;

  localparam logic [DW-1:0] ONE  = DW'(1);
  localparam logic [DW-1:0] TWO  = DW'(2);
  localparam logic [DW-1:0] DMAX = DW'(MAX_DIM);

  logic [SUM_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] row_count_r, col_count_r;
  logic [DW-1:0]    load_row_r, load_col_r;
  logic [SUM_W-1:0] run_sum_r;
  logic             ready_r;

  logic [SUM_W-1:0] elem_r;
  logic [DW-1:0]    cur_row_r, cur_col_r;
  logic             first_row_r;

  logic [DW-1:0]    q_top_r, q_left_r, q_bot_r;
  status_t          q_status_r;
  logic             q_t_zero_r, q_l_zero_r;
  logic [SUM_W-1:0] part_r;

  logic [SUM_W-1:0] rd_a_r, rd_b_r;
  logic [SUM_W-1:0] sum_r;
  status_t          status_r;
  logic             out_valid_r;

  logic [DW-1:0]    rows, cols, rc_ext, rr_ext;
  logic [DW-1:0]    ld_row, ld_col;
  logic [DW-1:0]    top_e, left_e, bot_e, right_e;
  logic signed [EB-1:0] elem_raw;
  logic [SUM_W-1:0] elem_ext;
  logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  logic             mem_we;
  logic [SUM_W-1:0] run_nxt, wr_data, above;
  status_t          status_nxt;
  logic [SUM_W-1:0] corner, sum_nxt;
  logic             cfg_hit;

  assign rr_ext = DW'(row_count_r);
  assign rc_ext = DW'(col_count_r);
  assign rows = (rr_ext == '0) ? ONE : ((rr_ext > DMAX) ? DMAX : rr_ext);
  assign cols = (rc_ext == '0) ? ONE : ((rc_ext > DMAX) ? DMAX : rc_ext);

  assign ld_row = (ready_r || load_row_r == '0 || load_row_r > rows) ? ONE : load_row_r;
  assign ld_col = (ready_r || load_col_r == '0 || load_col_r > cols) ? ONE : load_col_r;

  assign top_e   = DW'(in_top_row);
  assign left_e  = DW'(in_left_col);
  assign bot_e   = DW'(in_bottom_row);
  assign right_e = DW'(in_right_col);

  assign elem_raw = in_value[EB-1:0];
  assign elem_ext = SUM_W'(elem_raw);

  always_comb begin
    if (!ready_r) begin
      status_nxt = ST_NOT_READY;
    end else if (top_e == '0 || top_e > bot_e || bot_e > rows ||
                 left_e == '0 || left_e > right_e || right_e > cols) begin
      status_nxt = ST_BAD_BOUNDS;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_comb begin
    if (cmd.query_second) begin
      rd_addr_a = {IW'(q_bot_r - ONE), IW'(q_left_r - TWO)};
      rd_addr_b = {IW'(q_top_r - TWO), IW'(q_left_r - TWO)};
    end else if (cmd.accept_query) begin
      rd_addr_a = {IW'(bot_e - ONE), IW'(right_e - ONE)};
      rd_addr_b = {IW'(top_e - TWO), IW'(right_e - ONE)};
    end else begin
      rd_addr_a = {IW'(ld_row - TWO), IW'(ld_col - ONE)};
      rd_addr_b = '0;
    end
  end

  assign run_nxt = run_sum_r + elem_r;
  assign above   = first_row_r ? '0 : rd_a_r;
  assign wr_data = above + run_nxt;
  assign wr_addr = {IW'(cur_row_r - ONE), IW'(cur_col_r - ONE)};
  assign mem_we  = cmd.load_write;

  assign corner  = q_l_zero_r ? '0 : (rd_a_r - (q_t_zero_r ? '0 : rd_b_r));
  assign sum_nxt = (q_status_r == ST_OK) ? (part_r - corner) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_ROW_COUNT, CFG_COL_COUNT: cfg_hit = 1'b1;
        default:                      cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(MAX_DIM);
      col_count_r <= CNT_W'(MAX_DIM);
      load_row_r  <= ONE;
      load_col_r  <= ONE;
      run_sum_r   <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.query_finish;
      if (cfg_hit) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          row_count_r <= cfg_data;
        end else begin
          col_count_r <= cfg_data;
        end
        load_row_r <= ONE;
        load_col_r <= ONE;
        run_sum_r  <= '0;
        ready_r    <= 1'b0;
      end else if (cmd.accept_load) begin
        if (ready_r) begin
          run_sum_r <= '0;
          ready_r   <= 1'b0;
        end
      end else if (cmd.load_write) begin
        if (cur_col_r >= cols) begin
          load_col_r <= ONE;
          run_sum_r  <= '0;
          if (cur_row_r >= rows) begin
            load_row_r <= ONE;
            ready_r    <= 1'b1;
          end else begin
            load_row_r <= cur_row_r + ONE;
          end
        end else begin
          load_col_r <= cur_col_r + ONE;
          run_sum_r  <= run_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_load) begin
      elem_r      <= elem_ext;
      cur_row_r   <= ld_row;
      cur_col_r   <= ld_col;
      first_row_r <= (ld_row == ONE);
    end
    if (cmd.accept_query) begin
      q_top_r    <= top_e;
      q_left_r   <= left_e;
      q_bot_r    <= bot_e;
      q_status_r <= status_nxt;
      q_t_zero_r <= (top_e == ONE);
      q_l_zero_r <= (left_e == ONE);
    end
    if (cmd.query_second) begin
      part_r <= rd_a_r - (q_t_zero_r ? '0 : rd_b_r);
    end
    if (cmd.query_finish) begin
      sum_r    <= sum_nxt;
      status_r <= q_status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rect_sum = sum_r;
  assign out_status   = status_r;

  `SARS_ASSERT_IMPL(a_strobe_after_finish, clk, rst_n, out_valid_r,
                    $past(cmd.query_finish), "result strobe without finished query")
  `SARS_ASSERT_IMPL(a_error_sum_zero, clk, rst_n, out_valid_r && status_r != ST_OK,
                    sum_r == '0, "nonzero sum on error status")
  `SARS_ASSERT_NEXT(a_last_load_ready, clk, rst_n,
                    cmd.load_write && cur_col_r >= cols && cur_row_r >= rows,
                    ready_r, "matrix not marked ready after last element")

endmodule

// File: src/summed_area_rectangle_sum.sv
// Summed-area rectangle sum. A load item (in_func 0) first reads the
// entry above from the table memory, then writes the new integral entry.
// A query item (in_func 1) makes two pairs of reads on the dual-port table
// memory and a final add, and its result appears on out_rect_sum/out_status
// with out_valid high for one cycle right after busy falls; the result must
// be taken in that cycle, there is no hold-off. busy stays low between
// items, so a new start is taken while a result is shown. The table holds
// 2**(2*clog2(MAX_DIM)) 28-bit entries and needs no clearing after reset; a
// query before a whole matrix has been loaded gets status ST_NOT_READY and a zero sum.
// Depends on sars_pkg, sars_ctrl and sars_dp.
module summed_area_rectangle_sum #(
  parameter int MAX_DIM      = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [sars_pkg::VALUE_W-1:0]  in_value,
  input  logic [sars_pkg::POS_W-1:0]           in_top_row,
  input  logic [sars_pkg::POS_W-1:0]           in_left_col,
  input  logic [sars_pkg::POS_W-1:0]           in_bottom_row,
  input  logic [sars_pkg::POS_W-1:0]           in_right_col,
  output logic                                 out_valid,
  output logic signed [sars_pkg::SUM_W-1:0]    out_rect_sum,
  output logic [sars_pkg::STATUS_W-1:0]        out_status,
  input  logic                                 cfg_we,
  input  logic [sars_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sars_pkg::CNT_W-1:0]           cfg_data
);
  import sars_pkg::*;

  sars_cmd_t cmd;

  sars_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .busy  (busy),
    .cmd   (cmd)
  );

  sars_dp #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .in_top_row    (in_top_row),
    .in_left_col   (in_left_col),
    .in_bottom_row (in_bottom_row),
    .in_right_col  (in_right_col),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_rect_sum  (out_rect_sum),
    .out_status    (out_status)
  );

endmodule
